// File: hw/rtl/nec_ir_pkg.sv
// ----------------------------------------------------------------------------
// NEC IR decoder package
// Shared types, register indexes and reset values for the NEC infrared
// frame decoder.
// ----------------------------------------------------------------------------
package nec_ir_pkg;

   typedef enum logic [1:0] {
      PHASE_IDLE    = 2'd0,
      PHASE_LEADER  = 2'd1,
      PHASE_MESSAGE = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      MODE_EDGE     = 2'd0,
      MODE_OVERFLOW = 2'd1,
      MODE_READ     = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      CSR_ADDRESS_LOW   = 2'd0,
      CSR_ADDRESS_HIGH  = 2'd1,
      CSR_LEADER_THRESH = 2'd2,
      CSR_ONE_THRESH    = 2'd3
   } csr_index_type;

   localparam int unsigned CSR_ADDR_WIDTH = 4;
   localparam int unsigned CSR_DATA_WIDTH = 32;
   localparam int unsigned REQ_DATA_WIDTH = 16;
   localparam int unsigned RSP_DATA_WIDTH = 16;

   localparam logic [7:0] ADDRESS_LOW_RESET   = 8'hEE;
   localparam logic [7:0] ADDRESS_HIGH_RESET  = 8'h87;
   localparam logic [7:0] LEADER_THRESH_RESET = 8'd105;
   localparam logic [7:0] ONE_THRESH_RESET    = 8'd35;

endpackage

// File: hw/rtl/nec_ir_frame_decoder_unit.sv
// ----------------------------------------------------------------------------
// NEC IR frame decoder unit
// Decodes NEC infrared frames from timer overflow and line edge events; holds
// the last matched command byte, or the last frame's command after a short leader.
// ----------------------------------------------------------------------------
// A request transfer passes through the input register, then the result
// register; a stall on the result side holds both.
// Throughput: one event per cycle while the result side takes results; the decode
// step lies combinationally between the input register and the result register.
// Reset clears the decoder state, the pending command and both pipeline
// stages, and returns the configuration registers to their default values.
module nec_ir_frame_decoder_unit (
   input  logic        clock,
   input  logic        reset,
   // Request stream.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [0] line_level, [8:1] elapsed_ticks, zero fill
   input  logic [1:0]  req_tuser,   // [1:0] mode
   // Response stream.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [1:0] decoder_state, [9:2] command_code, zero fill
   // Configuration port.
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic                   out_free;
   logic                   s1_fire;
   logic                   req_fire;
   logic                   csr_write;

   logic                   s1_valid_ff, s1_valid_in;
   logic [1:0]             s1_mode_ff;
   logic                   s1_level_ff;
   logic [7:0]             s1_ticks_ff;

   nec_ir_pkg::phase_type  phase_ff, phase_in;
   logic [31:0]            frame_bits_ff, frame_bits_in;
   logic [4:0]             bit_pos_ff, bit_pos_in;
   logic [7:0]             pending_ff, pending_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [1:0]             rsp_state_ff;
   logic [7:0]             rsp_command_ff;
   logic [7:0]             command_in;

   logic [7:0]             addr_low_ff, addr_high_ff, leader_thr_ff, one_thr_ff;

   logic [31:0]            frame_set;
   logic [4:0]             bit_pos_next;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s1_fire    = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   assign s1_valid_in  = req_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = s1_fire ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_mode_ff  <= req_tuser;
         s1_level_ff <= req_tdata[0];
         s1_ticks_ff <= req_tdata[8:1];
      end
      if (s1_fire) begin
         rsp_state_ff   <= phase_in;
         rsp_command_ff <= command_in;
      end
   end

   always_comb begin
      frame_set            = frame_bits_ff;
      frame_set[bit_pos_ff] = frame_bits_ff[bit_pos_ff] | (s1_ticks_ff > one_thr_ff);
      bit_pos_next         = bit_pos_ff + 5'd1;

      phase_in      = phase_ff;
      frame_bits_in = frame_bits_ff;
      bit_pos_in    = bit_pos_ff;
      pending_in    = pending_ff;
      command_in    = pending_ff;

      if (s1_fire) begin
         case (s1_mode_ff)
            nec_ir_pkg::MODE_EDGE: begin
               if (s1_level_ff) begin
                  case (phase_ff)
                     nec_ir_pkg::PHASE_LEADER: begin
                        if (s1_ticks_ff > leader_thr_ff) begin
                           phase_in      = nec_ir_pkg::PHASE_MESSAGE;
                           bit_pos_in    = 5'd0;
                           frame_bits_in = 32'd0;
                        end else begin
                           phase_in   = nec_ir_pkg::PHASE_IDLE;
                           pending_in = frame_bits_ff[23:16];
                        end
                     end
                     nec_ir_pkg::PHASE_MESSAGE: begin
                        frame_bits_in = frame_set;
                        bit_pos_in    = bit_pos_next;
                        if (bit_pos_next == 5'd0) begin
                           phase_in = nec_ir_pkg::PHASE_IDLE;
                           if (frame_set[7:0] == addr_low_ff &&
                               frame_set[15:8] == addr_high_ff) begin
                              pending_in = frame_set[23:16];
                           end
                        end
                     end
                     default: begin
                     end
                  endcase
               end
               command_in = pending_in;
            end
            nec_ir_pkg::MODE_OVERFLOW: begin
               if (phase_ff == nec_ir_pkg::PHASE_IDLE && s1_level_ff) begin
                  phase_in = nec_ir_pkg::PHASE_LEADER;
               end
            end
            nec_ir_pkg::MODE_READ: begin
               pending_in = 8'd0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         phase_ff      <= nec_ir_pkg::PHASE_IDLE;
         frame_bits_ff <= 32'd0;
         bit_pos_ff    <= 5'd0;
         pending_ff    <= 8'd0;
      end else begin
         s1_valid_ff   <= s1_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         phase_ff      <= phase_in;
         frame_bits_ff <= frame_bits_in;
         bit_pos_ff    <= bit_pos_in;
         pending_ff    <= pending_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_low_ff   <= nec_ir_pkg::ADDRESS_LOW_RESET;
         addr_high_ff  <= nec_ir_pkg::ADDRESS_HIGH_RESET;
         leader_thr_ff <= nec_ir_pkg::LEADER_THRESH_RESET;
         one_thr_ff    <= nec_ir_pkg::ONE_THRESH_RESET;
      end else if (csr_write) begin
         case (csr_paddr[3:2])
            nec_ir_pkg::CSR_ADDRESS_LOW:   addr_low_ff   <= csr_pwdata[7:0];
            nec_ir_pkg::CSR_ADDRESS_HIGH:  addr_high_ff  <= csr_pwdata[7:0];
            nec_ir_pkg::CSR_LEADER_THRESH: leader_thr_ff <= csr_pwdata[7:0];
            nec_ir_pkg::CSR_ONE_THRESH:    one_thr_ff    <= csr_pwdata[7:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         nec_ir_pkg::CSR_ADDRESS_LOW:   csr_prdata = {24'd0, addr_low_ff};
         nec_ir_pkg::CSR_ADDRESS_HIGH:  csr_prdata = {24'd0, addr_high_ff};
         nec_ir_pkg::CSR_LEADER_THRESH: csr_prdata = {24'd0, leader_thr_ff};
         nec_ir_pkg::CSR_ONE_THRESH:    csr_prdata = {24'd0, one_thr_ff};
         default:                       csr_prdata = 32'd0;
      endcase
   end

   assign csr_pready = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_command_ff, rsp_state_ff};

   // A read transfer leaves no command pending.
   assert property (@(posedge clock) disable iff (reset)
      s1_fire && s1_mode_ff == nec_ir_pkg::MODE_READ |=> pending_ff == 8'd0)
      else $error("pending command not cleared by read");

   // The bit counter only moves while message bits are being received.
   assert property (@(posedge clock) disable iff (reset)
      phase_ff != nec_ir_pkg::PHASE_MESSAGE |-> bit_pos_ff == 5'd0)
      else $error("bit position nonzero outside message phase");

   // Every processed event produces a response in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      s1_fire |=> rsp_valid_ff)
      else $error("processed event produced no response");

   // The request side stalls only when both stages are full and blocked.
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> s1_valid_ff && rsp_valid_ff && !rsp_tready)
      else $error("request stalled without backpressure");

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// NEC IR frame decoder testbench
// Drives timer overflow, line edge, read and unused events into the decoder
// and checks every result against a cycle-free model of the decode state.
// Frames are mostly well formed with random content and several register
// settings, mixed with stray events, cut-off frames and stalls on both sides.
// ----------------------------------------------------------------------------
module tb_top;

   localparam logic [1:0] MODE_UNUSED = 2'd3;

   typedef struct packed {
      nec_ir_pkg::phase_type state;
      logic [7:0]            command;
   } decoder_report_type;

   class ir_frame_tracker;
      logic [7:0]            address_low;
      logic [7:0]            address_high;
      logic [7:0]            leader_threshold;
      logic [7:0]            one_threshold;
      nec_ir_pkg::phase_type phase;
      logic [31:0]           frame_bits;
      logic [4:0]            bit_count;
      logic [7:0]            held_command;
      decoder_report_type    reports_due[$];
      int                    error_count;

      function new();
         address_low      = nec_ir_pkg::ADDRESS_LOW_RESET;
         address_high     = nec_ir_pkg::ADDRESS_HIGH_RESET;
         leader_threshold = nec_ir_pkg::LEADER_THRESH_RESET;
         one_threshold    = nec_ir_pkg::ONE_THRESH_RESET;
         phase            = nec_ir_pkg::PHASE_IDLE;
         frame_bits       = '0;
         bit_count        = '0;
         held_command     = '0;
         error_count      = 0;
      endfunction

      function void set_register(nec_ir_pkg::csr_index_type index, logic [7:0] value);
         case (index)
            nec_ir_pkg::CSR_ADDRESS_LOW:   address_low = value;
            nec_ir_pkg::CSR_ADDRESS_HIGH:  address_high = value;
            nec_ir_pkg::CSR_LEADER_THRESH: leader_threshold = value;
            nec_ir_pkg::CSR_ONE_THRESH:    one_threshold = value;
            default: ;
         endcase
      endfunction

      function void accept_event(logic [1:0] mode, logic level, logic [7:0] ticks);
         decoder_report_type report;
         case (mode)
            nec_ir_pkg::MODE_EDGE: begin
               if (level && phase == nec_ir_pkg::PHASE_LEADER) begin
                  if (ticks > leader_threshold) begin
                     phase      = nec_ir_pkg::PHASE_MESSAGE;
                     bit_count  = '0;
                     frame_bits = '0;
                  end else begin
                     phase        = nec_ir_pkg::PHASE_IDLE;
                     held_command = frame_bits[23:16];
                  end
               end else if (level && phase == nec_ir_pkg::PHASE_MESSAGE) begin
                  if (ticks > one_threshold) frame_bits[bit_count] = 1'b1;
                  bit_count = bit_count + 5'd1;
                  if (bit_count == 5'd0) begin
                     if (frame_bits[7:0] == address_low && frame_bits[15:8] == address_high)
                        held_command = frame_bits[23:16];
                     phase = nec_ir_pkg::PHASE_IDLE;
                  end
               end
               report.command = held_command;
            end
            nec_ir_pkg::MODE_OVERFLOW: begin
               if (phase == nec_ir_pkg::PHASE_IDLE && level) phase = nec_ir_pkg::PHASE_LEADER;
               report.command = held_command;
            end
            nec_ir_pkg::MODE_READ: begin
               report.command = held_command;
               held_command   = '0;
            end
            default: report.command = held_command;
         endcase
         report.state = phase;
         reports_due.push_back(report);
      endfunction

      function void compare_field(string field, int expected_value, int actual_value);
         if (expected_value != actual_value) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, field, expected_value, actual_value);
            error_count++;
         end
      endfunction

      function void check_report(logic [15:0] word);
         decoder_report_type report;
         if (reports_due.size() == 0) begin
            $display("%0t: unexpected result transfer, actual 0x%04h", $time, word);
            error_count++;
            return;
         end
         report = reports_due.pop_front();
         compare_field("decoder_state", int'(report.state), int'(word[1:0]));
         compare_field("command_code", int'(report.command), int'(word[9:2]));
         compare_field("zero fill", 0, int'(word[15:10]));
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   ir_frame_tracker frame_tracker = new();
   logic            sender_pauses_on = 1'b1;
   logic            receiver_pauses_on = 1'b1;
   logic            hold_off_requested = 1'b0;
   int              items_sent = 0;

   nec_ir_frame_decoder_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #1 clock = ~clock;

   initial begin
      #400000;
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin : result_side
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) frame_tracker.check_report(rsp_tdata);
         if (hold_off_requested) begin
            hold_off_requested = 1'b0;
            hold_left = 120;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= !(receiver_pauses_on && $urandom_range(0, 99) < 34);
         end
      end
   end

   task automatic send_event(logic [1:0] mode, logic level, logic [7:0] ticks);
      while (sender_pauses_on && $urandom_range(0, 99) < 34) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {7'd0, ticks, level};
      do @(posedge clock); while (!req_tready);
      frame_tracker.accept_event(mode, level, ticks);
      items_sent++;
   endtask

   function automatic logic [7:0] ticks_over(logic [7:0] limit);
      if (limit == 8'hFF) return 8'hFF;
      if ($urandom_range(0, 4) == 0) return limit + 8'd1;
      return 8'($urandom_range(int'(limit) + 1, 255));
   endfunction

   function automatic logic [7:0] ticks_within(logic [7:0] limit);
      if ($urandom_range(0, 4) == 0) return limit;
      return 8'($urandom_range(0, int'(limit)));
   endfunction

   task automatic send_stray_event();
      logic [1:0] mode;
      mode = 2'($urandom);
      send_event(mode, (mode == nec_ir_pkg::MODE_EDGE) ? 1'b0 : 1'($urandom), 8'($urandom));
   endtask

   task automatic send_frame();
      logic [31:0] frame;
      int          stop_at;
      frame[7:0]   = ($urandom_range(0, 9) < 7) ? frame_tracker.address_low : 8'($urandom);
      frame[15:8]  = ($urandom_range(0, 9) < 7) ? frame_tracker.address_high : 8'($urandom);
      frame[23:16] = 8'($urandom);
      frame[31:24] = $urandom_range(0, 1) ? ~frame[23:16] : 8'($urandom);
      stop_at      = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : 32;
      send_event(nec_ir_pkg::MODE_OVERFLOW, 1'b1, 8'($urandom));
      if ($urandom_range(0, 3) == 0) begin
         send_event(nec_ir_pkg::MODE_EDGE, 1'b1,
                    ticks_within(frame_tracker.leader_threshold));
      end else begin
         send_event(nec_ir_pkg::MODE_EDGE, 1'b1, ticks_over(frame_tracker.leader_threshold));
         for (int b = 0; b < stop_at; b++) begin
            if ($urandom_range(0, 19) == 0) send_stray_event();
            send_event(nec_ir_pkg::MODE_EDGE, 1'b1,
                       frame[b] ? ticks_over(frame_tracker.one_threshold)
                                : ticks_within(frame_tracker.one_threshold));
         end
      end
      if ($urandom_range(0, 1)) send_event(nec_ir_pkg::MODE_READ, 1'($urandom), 8'($urandom));
   endtask

   task automatic run_traffic(int count);
      int stop_at;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 4)) send_event(2'($urandom), 1'($urandom), 8'($urandom));
         end else begin
            send_frame();
         end
      end
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (frame_tracker.reports_due.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(nec_ir_pkg::csr_index_type index, logic [7:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= {24'($urandom), value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      frame_tracker.set_register(index, value);
      @(posedge clock);
   endtask

   task automatic configure(logic [7:0] address_low, logic [7:0] address_high,
                            logic [7:0] leader_threshold, logic [7:0] one_threshold);
      settle();
      write_register(nec_ir_pkg::CSR_ADDRESS_LOW, address_low);
      write_register(nec_ir_pkg::CSR_ADDRESS_HIGH, address_high);
      write_register(nec_ir_pkg::CSR_LEADER_THRESH, leader_threshold);
      write_register(nec_ir_pkg::CSR_ONE_THRESH, one_threshold);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_event(MODE_UNUSED, 1'b1, 8'hFF);
      send_event(nec_ir_pkg::MODE_EDGE, 1'b0, 8'h00);
      send_event(nec_ir_pkg::MODE_EDGE, 1'b1, 8'hFF);
      send_event(nec_ir_pkg::MODE_OVERFLOW, 1'b0, 8'h00);
      send_event(nec_ir_pkg::MODE_READ, 1'b0, 8'h00);
      send_event(nec_ir_pkg::MODE_OVERFLOW, 1'b1, 8'hAA);
      send_event(nec_ir_pkg::MODE_OVERFLOW, 1'b1, 8'h55);
      send_event(nec_ir_pkg::MODE_EDGE, 1'b0, 8'hFF);
      send_event(MODE_UNUSED, 1'b0, 8'h00);
      send_event(nec_ir_pkg::MODE_EDGE, 1'b1, nec_ir_pkg::LEADER_THRESH_RESET);
      send_event(nec_ir_pkg::MODE_OVERFLOW, 1'b1, 8'h00);
      send_event(nec_ir_pkg::MODE_EDGE, 1'b1, nec_ir_pkg::LEADER_THRESH_RESET + 8'd1);
      send_event(nec_ir_pkg::MODE_OVERFLOW, 1'b1, 8'hFF);
      send_event(nec_ir_pkg::MODE_EDGE, 1'b0, 8'h00);
      send_event(MODE_UNUSED, 1'b1, 8'h00);
      send_event(nec_ir_pkg::MODE_READ, 1'b1, 8'hFF);
      send_event(nec_ir_pkg::MODE_EDGE, 1'b1, nec_ir_pkg::ONE_THRESH_RESET);
      send_event(nec_ir_pkg::MODE_EDGE, 1'b1, nec_ir_pkg::ONE_THRESH_RESET + 8'd1);
      send_event(nec_ir_pkg::MODE_EDGE, 1'b1, 8'h00);
      send_event(nec_ir_pkg::MODE_EDGE, 1'b1, 8'hFF);
      run_traffic(130);

      configure(8'($urandom), 8'($urandom), 8'($urandom_range(40, 200)),
                8'($urandom_range(10, 120)));
      sender_pauses_on   = 1'b0;
      receiver_pauses_on = 1'b0;
      hold_off_requested = 1'b1;
      run_traffic(110);
      sender_pauses_on   = 1'b1;
      receiver_pauses_on = 1'b1;

      configure(8'h00, 8'hFF, 8'h00, 8'h00);
      run_traffic(90);
      configure(8'hFF, 8'h00, 8'hFF, 8'hFF);
      run_traffic(50);
      configure(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      hold_off_requested = 1'b1;
      run_traffic(100);

      settle();
      repeat (8) @(posedge clock);
      if (frame_tracker.error_count == 0 && frame_tracker.reports_due.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
